### hw/rtl/rpbp_pkg.sv
package rpbp_pkg;

	// header layout
	localparam logic [15:0] HEADER_BYTES = 16'd20;
	localparam logic [15:0] AUTH_BYTES   = 16'd16;
	localparam logic [15:0] AUTH_FIRST   = 16'd4;
	localparam logic [15:0] AUTH_LAST    = AUTH_FIRST + AUTH_BYTES - 16'd1;
	localparam logic [7:0]  ATTR_MIN_LEN = 8'd2;
	localparam logic [7:0]  COUNT_MAX    = 8'hFF;
	localparam logic [15:0] POS_MAX      = 16'hFFFF;

	// byte roles, also used as the parser phase
	typedef enum logic [3:0] {
		KIND_CODE,
		KIND_ID,
		KIND_LEN_HI,
		KIND_LEN_LO,
		KIND_AUTH,
		KIND_ATTR_TYPE,
		KIND_ATTR_LEN,
		KIND_ATTR_DATA,
		KIND_TRAIL
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE,
		ERR_SHORT_LEN,
		ERR_ATTR_LEN,
		ERR_OVERRUN
	} err_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       packet_start;
	} item_t;

	typedef struct packed {
		kind_t       byte_kind;
		logic [7:0]  byte_echo;
		logic [7:0]  field_offset;
		logic [7:0]  attribute_index;
		logic [7:0]  current_attr_type;
		logic [7:0]  current_attr_length;
		logic [15:0] packet_length;
		logic        attribute_end;
		logic        packet_end;
		err_t        error_code;
	} result_t;

endpackage

### hw/rtl/rpbp_if.sv
interface rpbp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_value;
	logic       packet_start;

	modport source (output valid, output byte_value, output packet_start, input ready);
	modport sink (input valid, input byte_value, input packet_start, output ready);
endinterface

interface rpbp_tag_if;
	logic        valid;
	logic        ready;
	logic [3:0]  byte_kind;
	logic [7:0]  byte_echo;
	logic [7:0]  field_offset;
	logic [7:0]  attribute_index;
	logic [7:0]  current_attr_type;
	logic [7:0]  current_attr_length;
	logic [15:0] packet_length;
	logic        attribute_end;
	logic        packet_end;
	logic [1:0]  error_code;

	modport source (
		output valid, output byte_kind, output byte_echo, output field_offset,
		output attribute_index, output current_attr_type, output current_attr_length,
		output packet_length, output attribute_end, output packet_end, output error_code,
		input ready
	);
	modport sink (
		input valid, input byte_kind, input byte_echo, input field_offset,
		input attribute_index, input current_attr_type, input current_attr_length,
		input packet_length, input attribute_end, input packet_end, input error_code,
		output ready
	);
endinterface

### hw/rtl/radius_packet_byte_parser_unit.sv
// a byte request is registered in stage 1 and its tag in stage 2; a held tag can keep the byte waiting in stage 1
// one byte per cycle while the sink takes each tag; the parser state updates once per byte
// a held tag stalls intake once the input register is also full; ready passes straight through
// reset (arst_n low, asynchronous): both stages empty, parser back in the code phase,
// counters, held lengths and the sticky error cleared; no clearing pass is needed
module radius_packet_byte_parser_unit
	import rpbp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	rpbp_byte_if.sink   byte_in,
	rpbp_tag_if.source  tag_out
);

	// stage 1: registered byte request
	logic    valid_s1;
	item_t   item_s1;
	// set when the stage 1 byte moves into the output register
	logic    advance;
	// tag of the stage 1 byte, from the parser state as it stands now
	result_t res;

	rpbp_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_in  (byte_in),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// parser state advances exactly once per byte, as it leaves stage 1
	rpbp_tagger u_tagger (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.res    (res)
	);

	// stage 2: tag request held until the sink takes it
	rpbp_out_stage u_out_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.res      (res),
		.advance  (advance),
		.tag_out  (tag_out)
	);

endmodule

### hw/rtl/rpbp_in_stage.sv
module rpbp_in_stage
	import rpbp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	rpbp_byte_if.sink   byte_in,
	input  logic        advance,
	output logic        valid_s1,
	output item_t       item_s1
);

	assign byte_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_in.ready) begin
			valid_s1 <= byte_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.valid && byte_in.ready) begin
			item_s1.byte_value   <= byte_in.byte_value;
			item_s1.packet_start <= byte_in.packet_start;
		end
	end

endmodule

### hw/rtl/rpbp_tagger.sv
module rpbp_tagger
	import rpbp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  item_t   item,
	output result_t res
);

	kind_t       phase_q, phase_n;
	logic [15:0] pos_q, pos_n;
	logic [15:0] dlen_q, dlen_n;
	logic [7:0]  apos_q, apos_n;
	logic [7:0]  atype_q, atype_n;
	logic [7:0]  alen_q, alen_n;
	logic [7:0]  acount_q, acount_n;
	err_t        err_q, err_n;

	// state seen by this byte, after a packet start has cleared it
	kind_t       ph;
	logic [15:0] pos, dlen;
	logic [7:0]  apos, atype, alen, acount;
	err_t        err;
	kind_t       kind;
	logic [7:0]  b;
	logic [16:0] attr_reach;

	always_comb begin
		b = item.byte_value;
		if (item.packet_start) begin
			ph = KIND_CODE; pos = '0; dlen = '0; apos = '0;
			atype = '0; alen = '0; acount = '0; err = ERR_NONE;
		end else begin
			ph = phase_q; pos = pos_q; dlen = dlen_q; apos = apos_q;
			atype = atype_q; alen = alen_q; acount = acount_q; err = err_q;
		end

		kind = ph;
		if ((ph == KIND_ATTR_TYPE || ph == KIND_ATTR_LEN || ph == KIND_ATTR_DATA)
				&& pos >= dlen) begin
			kind = KIND_TRAIL;
		end

		phase_n  = ph;
		dlen_n   = dlen;
		apos_n   = apos;
		atype_n  = atype;
		alen_n   = alen;
		acount_n = acount;
		err_n    = err;
		attr_reach = {1'b0, pos} + {9'd0, b};

		res = '0;
		res.byte_kind = kind;
		res.byte_echo = b;

		case (kind)
			KIND_CODE: phase_n = KIND_ID;
			KIND_ID:   phase_n = KIND_LEN_HI;
			KIND_LEN_HI: begin
				dlen_n  = {b, 8'd0};
				phase_n = KIND_LEN_LO;
			end
			KIND_LEN_LO: begin
				dlen_n = {dlen[15:8], b};
				if ({dlen[15:8], b} < HEADER_BYTES && err == ERR_NONE) begin
					err_n = ERR_SHORT_LEN;
				end
				phase_n = KIND_AUTH;
			end
			KIND_AUTH: begin
				res.field_offset = 8'(pos - AUTH_FIRST);
				if (pos >= AUTH_LAST) begin
					phase_n = KIND_ATTR_TYPE;
				end
			end
			KIND_ATTR_TYPE: begin
				if (pos == HEADER_BYTES) begin
					acount_n = '0;
				end else if (acount < COUNT_MAX) begin
					acount_n = acount + 8'd1;
				end
				atype_n = b;
				alen_n  = '0;
				apos_n  = 8'd1;
				phase_n = KIND_ATTR_LEN;
				res.attribute_index   = acount_n;
				res.current_attr_type = b;
			end
			KIND_ATTR_LEN: begin
				alen_n = b;
				// attribute covers pos-1 .. pos-1+len-1
				if (err == ERR_NONE) begin
					if (b < ATTR_MIN_LEN) begin
						err_n = ERR_ATTR_LEN;
					end else if (attr_reach > {1'b0, dlen} + 17'd1) begin
						err_n = ERR_OVERRUN;
					end
				end
				if (b <= ATTR_MIN_LEN) begin
					res.attribute_end = 1'b1;
					apos_n  = '0;
					phase_n = KIND_ATTR_TYPE;
				end else begin
					apos_n  = ATTR_MIN_LEN;
					phase_n = KIND_ATTR_DATA;
				end
				res.attribute_index     = acount;
				res.current_attr_type   = atype;
				res.current_attr_length = b;
			end
			KIND_ATTR_DATA: begin
				res.field_offset = apos - ATTR_MIN_LEN;
				if ({1'b0, apos} + 9'd1 >= {1'b0, alen}) begin
					res.attribute_end = 1'b1;
					apos_n  = '0;
					phase_n = KIND_ATTR_TYPE;
				end else begin
					apos_n = apos + 8'd1;
				end
				res.attribute_index     = acount;
				res.current_attr_type   = atype;
				res.current_attr_length = alen;
			end
			default: phase_n = KIND_TRAIL;
		endcase

		if (phase_n >= KIND_AUTH || kind == KIND_TRAIL) begin
			res.packet_length = dlen_n;
			res.packet_end    = (dlen_n != '0) && (pos == dlen_n - 16'd1);
		end

		pos_n = (pos < POS_MAX) ? pos + 16'd1 : pos;
		res.error_code = err_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= KIND_CODE;
			pos_q    <= '0;
			dlen_q   <= '0;
			apos_q   <= '0;
			atype_q  <= '0;
			alen_q   <= '0;
			acount_q <= '0;
			err_q    <= ERR_NONE;
		end else if (step) begin
			phase_q  <= phase_n;
			pos_q    <= pos_n;
			dlen_q   <= dlen_n;
			apos_q   <= apos_n;
			atype_q  <= atype_n;
			alen_q   <= alen_n;
			acount_q <= acount_n;
			err_q    <= err_n;
		end
	end

endmodule

### hw/rtl/rpbp_out_stage.sv
module rpbp_out_stage
	import rpbp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid_s1,
	input  result_t     res,
	output logic        advance,
	rpbp_tag_if.source  tag_out
);

	logic    valid_s2;
	result_t res_s2;

	assign advance = valid_s1 && (!valid_s2 || tag_out.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (tag_out.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign tag_out.valid               = valid_s2;
	assign tag_out.byte_kind           = res_s2.byte_kind;
	assign tag_out.byte_echo           = res_s2.byte_echo;
	assign tag_out.field_offset        = res_s2.field_offset;
	assign tag_out.attribute_index     = res_s2.attribute_index;
	assign tag_out.current_attr_type   = res_s2.current_attr_type;
	assign tag_out.current_attr_length = res_s2.current_attr_length;
	assign tag_out.packet_length       = res_s2.packet_length;
	assign tag_out.attribute_end       = res_s2.attribute_end;
	assign tag_out.packet_end          = res_s2.packet_end;
	assign tag_out.error_code          = res_s2.error_code;

endmodule

### tb/tb.sv
module tb;
	import rpbp_pkg::*;

	typedef logic [7:0] byte_q_t[$];

	// random packet traffic, counted in bytes
	localparam int RANDOM_BYTES = 350;
	// watchdog, several times the slowest legal run
	localparam int CYCLE_LIMIT = 20000;
	// percentage of cycles in which each side holds back
	localparam int IDLE_PCT = 11;

	logic clk = 1'b0;
	logic arst_n;

	rpbp_byte_if byte_if ();
	rpbp_tag_if  tag_if ();

	radius_packet_byte_parser_unit i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_in (byte_if),
		.tag_out (tag_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// parser state as the tagger sees it, reset values at declaration
	kind_t       parse_phase = KIND_CODE;
	logic [15:0] parse_pos   = '0;
	logic [15:0] declared_len = '0;
	logic [7:0]  attr_pos    = '0;
	logic [7:0]  held_type   = '0;
	logic [7:0]  held_len    = '0;
	logic [7:0]  attr_count  = '0;
	err_t        sticky_err  = ERR_NONE;

	result_t pending_tags[$];
	int      mismatches   = 0;
	int      tags_checked = 0;
	int      cycle_count  = 0;
	// when set, neither side idles
	logic    no_idle      = 1'b0;

	// the first fault of a packet is the one kept
	function automatic void flag_fault(input err_t fault);
		if (sticky_err == ERR_NONE)
			sticky_err = fault;
	endfunction

	// expected tag for one byte, advancing the parser state
	function automatic result_t tag_byte(input logic [7:0] b, input logic start);
		result_t r;
		kind_t   k;
		int      p;
		r = '0;
		if (start) begin
			parse_phase  = KIND_CODE;
			parse_pos    = '0;
			declared_len = '0;
			attr_pos     = '0;
			held_type    = '0;
			held_len     = '0;
			attr_count   = '0;
			sticky_err   = ERR_NONE;
		end
		p = parse_pos;
		k = parse_phase;
		// attribute bytes at or past the declared length are trailing
		if ((k == KIND_ATTR_TYPE || k == KIND_ATTR_LEN || k == KIND_ATTR_DATA) &&
			p >= declared_len)
			k = KIND_TRAIL;

		case (k)
			KIND_CODE: parse_phase = KIND_ID;
			KIND_ID: parse_phase = KIND_LEN_HI;
			KIND_LEN_HI: begin
				declared_len = {b, 8'h00};
				parse_phase  = KIND_LEN_LO;
			end
			KIND_LEN_LO: begin
				declared_len[7:0] = b;
				if (declared_len < HEADER_BYTES)
					flag_fault(ERR_SHORT_LEN);
				parse_phase = KIND_AUTH;
			end
			KIND_AUTH: begin
				r.field_offset = 8'(p - 4);
				if (p >= AUTH_LAST)
					parse_phase = KIND_ATTR_TYPE;
			end
			KIND_ATTR_TYPE: begin
				// first attribute sits right after the header
				if (p == HEADER_BYTES)
					attr_count = '0;
				else if (attr_count != COUNT_MAX)
					attr_count = attr_count + 8'd1;
				held_type   = b;
				held_len    = '0;
				attr_pos    = 8'd1;
				parse_phase = KIND_ATTR_LEN;
				r.attribute_index   = attr_count;
				r.current_attr_type = b;
			end
			KIND_ATTR_LEN: begin
				held_len = b;
				if (b < ATTR_MIN_LEN)
					flag_fault(ERR_ATTR_LEN);
				else if (p - 1 + int'(b) > int'(declared_len))
					flag_fault(ERR_OVERRUN);
				// a bad length counts as the minimum, so the attribute ends here
				if (b <= ATTR_MIN_LEN) begin
					r.attribute_end = 1'b1;
					attr_pos        = '0;
					parse_phase     = KIND_ATTR_TYPE;
				end else begin
					attr_pos    = 8'd2;
					parse_phase = KIND_ATTR_DATA;
				end
				r.attribute_index     = attr_count;
				r.current_attr_type   = held_type;
				r.current_attr_length = b;
			end
			KIND_ATTR_DATA: begin
				r.field_offset = attr_pos - 8'd2;
				if ({1'b0, attr_pos} + 9'd1 >= {1'b0, held_len}) begin
					r.attribute_end = 1'b1;
					attr_pos        = '0;
					parse_phase     = KIND_ATTR_TYPE;
				end else begin
					attr_pos = attr_pos + 8'd1;
				end
				r.attribute_index     = attr_count;
				r.current_attr_type   = held_type;
				r.current_attr_length = held_len;
			end
			default: parse_phase = KIND_TRAIL;
		endcase

		r.byte_kind = k;
		r.byte_echo = b;
		// packet length shows from the len lo byte on
		if (parse_phase >= KIND_AUTH || k == KIND_TRAIL) begin
			r.packet_length = declared_len;
			if (declared_len != 16'd0 && p == int'(declared_len) - 1)
				r.packet_end = 1'b1;
		end
		if (parse_pos != POS_MAX)
			parse_pos = parse_pos + 16'd1;
		r.error_code = sticky_err;
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input logic [15:0] got,
		input logic [15:0] want);
		mismatches++;
		$display("tag %0d: %s got %0h, want %0h", tags_checked, what, got, want);
	endtask

	// offer one byte request, with a random gap in front, and wait for it to be taken
	task automatic send_byte(input logic [7:0] b, input logic start);
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			byte_if.valid <= 1'b0;
			@(posedge clk);
		end
		byte_if.valid        <= 1'b1;
		byte_if.byte_value   <= b;
		byte_if.packet_start <= start;
		do
			@(posedge clk);
		while (!byte_if.ready);
		pending_tags.push_back(tag_byte(b, start));
	endtask

	task automatic send_packet(input byte_q_t pkt);
		foreach (pkt[i])
			send_byte(pkt[i], i == 0);
	endtask

	// code, identifier, length and a random authenticator
	function automatic byte_q_t make_header(input logic [7:0] code, input logic [7:0] ident,
		input logic [15:0] len);
		byte_q_t h;
		h = {code, ident, len[15:8], len[7:0]};
		repeat (AUTH_BYTES)
			h.push_back(8'($urandom));
		return h;
	endfunction

	// the parser must treat the very first byte as a code byte even without a start
	task automatic test_no_start_after_reset();
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h13, 1'b0);
	endtask

	// length under the header size: header still tagged, the rest trailing
	task automatic test_short_length();
		byte_q_t pkt;
		pkt = make_header(8'h01, 8'hFF, 16'h0013);
		pkt = {pkt, 8'hAA, 8'h55, 8'hFF};
		send_packet(pkt);
		// zero length never flags a packet end
		pkt = make_header(8'h00, 8'h00, 16'h0000);
		pkt.push_back(8'h00);
		send_packet(pkt);
	endtask

	// attribute lengths of zero, one and exactly two
	task automatic test_attr_lengths();
		byte_q_t pkt;
		pkt = make_header(8'h02, 8'h10, 16'd26);
		pkt = {pkt, 8'h01, 8'h00, 8'hFF, 8'h01, 8'h02, 8'h02};
		send_packet(pkt);
	endtask

	// an attribute runs past the declared length, then trailing bytes follow
	task automatic test_overrun();
		byte_q_t pkt;
		pkt = make_header(8'h0B, 8'h7F, 16'd30);
		pkt = {pkt, 8'h1A, 8'h06, 8'h11, 8'h22, 8'h33, 8'h44};
		pkt = {pkt, 8'h4F, 8'hFF, 8'h80, 8'h01, 8'hFE, 8'h7F, 8'h00, 8'hFF};
		send_packet(pkt);
	endtask

	// a bad attribute length comes first, so the later overrun is not reported
	task automatic test_first_error_kept();
		byte_q_t pkt;
		pkt = make_header(8'h03, 8'h20, 16'd25);
		pkt = {pkt, 8'h05, 8'h01, 8'h06, 8'h09, 8'hC3, 8'h3C, 8'h99};
		send_packet(pkt);
	endtask

	// a new start in the middle of a packet cuts it short
	task automatic test_restart();
		byte_q_t pkt;
		pkt = make_header(8'h04, 8'h21, 16'd40);
		pkt = pkt[0:9];
		send_packet(pkt);
		pkt = make_header(8'h05, 8'h22, 16'd22);
		pkt = {pkt, 8'h50, 8'h02};
		send_packet(pkt);
	endtask

	// enough minimum-size attributes to saturate the attribute index,
	// sent as one unbroken stream with neither side idling
	task automatic test_index_saturation();
		byte_q_t pkt;
		no_idle = 1'b1;
		pkt = make_header(8'h01, 8'h33, 16'd580);
		repeat (280)
			pkt = {pkt, 8'($urandom), 8'h02};
		send_packet(pkt);
		no_idle = 1'b0;
	endtask

	// mostly well-formed packets with random content; some faulty, cut short or noise
	task automatic test_random_packets();
		byte_q_t     pkt;
		int          sent;
		int          shape;
		int          n_attr;
		int          alen;
		int          total;
		int          decl;
		logic [15:0] len16;
		sent = 0;
		while (sent < RANDOM_BYTES) begin
			shape = $urandom_range(11);
			if (shape == 11) begin
				// raw noise with stray starts
				repeat ($urandom_range(1, 24)) begin
					send_byte(8'($urandom), $urandom_range(7) == 0);
					sent++;
				end
			end else begin
				pkt = make_header(8'($urandom), 8'($urandom), 16'd0);
				n_attr = $urandom_range(4);
				if (shape == 8 && n_attr == 0)
					n_attr = 1;
				for (int i = 0; i < n_attr; i++) begin
					alen = (shape == 8 && i == 0) ? $urandom_range(1) : $urandom_range(2, 14);
					pkt.push_back(8'($urandom));
					pkt.push_back(8'(alen));
					for (int j = 2; j < alen; j++)
						pkt.push_back(8'($urandom));
				end
				total = pkt.size();
				case (shape)
					7: decl = total + $urandom_range(1, 65535 - total);
					9: decl = $urandom_range(19);
					10: decl = total - $urandom_range(1, 6);
					default: decl = total;
				endcase
				len16 = 16'(decl);
				pkt[2] = len16[15:8];
				pkt[3] = len16[7:0];
				if ($urandom_range(3) == 0)
					repeat ($urandom_range(1, 4))
						pkt.push_back(8'($urandom));
				if ($urandom_range(9) == 0)
					pkt = pkt[0:$urandom_range(pkt.size() - 1)];
				send_packet(pkt);
				sent += pkt.size();
			end
		end
	endtask

	// sink side: accept tag requests, holding back at random
	always @(posedge clk)
		tag_if.ready <= arst_n && (no_idle || $urandom_range(99) >= IDLE_PCT);

	// compare every accepted tag with the oldest expectation
	always @(posedge clk) begin
		result_t want;
		if (tag_if.valid === 1'b1 && tag_if.ready === 1'b1) begin
			if (pending_tags.size() == 0) begin
				flag_mismatch("unexpected tag", '0, '0);
			end else begin
				want = pending_tags.pop_front();
				if (tag_if.byte_kind !== want.byte_kind)
					flag_mismatch("byte_kind", tag_if.byte_kind, want.byte_kind);
				if (tag_if.byte_echo !== want.byte_echo)
					flag_mismatch("byte_echo", tag_if.byte_echo, want.byte_echo);
				if (tag_if.field_offset !== want.field_offset)
					flag_mismatch("field_offset", tag_if.field_offset, want.field_offset);
				if (tag_if.attribute_index !== want.attribute_index)
					flag_mismatch("attribute_index", tag_if.attribute_index,
						want.attribute_index);
				if (tag_if.current_attr_type !== want.current_attr_type)
					flag_mismatch("current_attr_type", tag_if.current_attr_type,
						want.current_attr_type);
				if (tag_if.current_attr_length !== want.current_attr_length)
					flag_mismatch("current_attr_length", tag_if.current_attr_length,
						want.current_attr_length);
				if (tag_if.packet_length !== want.packet_length)
					flag_mismatch("packet_length", tag_if.packet_length, want.packet_length);
				if (tag_if.attribute_end !== want.attribute_end)
					flag_mismatch("attribute_end", tag_if.attribute_end, want.attribute_end);
				if (tag_if.packet_end !== want.packet_end)
					flag_mismatch("packet_end", tag_if.packet_end, want.packet_end);
				if (tag_if.error_code !== want.error_code)
					flag_mismatch("error_code", tag_if.error_code, want.error_code);
			end
			tags_checked++;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		arst_n               = 1'b0;
		byte_if.valid        = 1'b0;
		byte_if.byte_value   = '0;
		byte_if.packet_start = 1'b0;
		tag_if.ready         = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_no_start_after_reset();
		test_short_length();
		test_attr_lengths();
		test_overrun();
		test_first_error_kept();
		test_restart();
		test_index_saturation();
		test_random_packets();

		byte_if.valid <= 1'b0;
		// drain the outstanding tags, then allow for the pipeline depth
		while (pending_tags.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

### files.f
hw/rtl/rpbp_pkg.sv
hw/rtl/rpbp_if.sv
hw/rtl/rpbp_in_stage.sv
hw/rtl/rpbp_tagger.sv
hw/rtl/rpbp_out_stage.sv
hw/rtl/radius_packet_byte_parser_unit.sv
tb/tb.sv
